[design/pie_pkg.sv]
`timescale 1ns / 1ps
// Package for the positional insert/erase array.
// Holds field widths, operation and status codes, and controller/datapath structs.
package pie_pkg;

  // Default number of storage slots
  localparam int CAPACITY_DEF = 1024;

  // Request and result field widths
  localparam int OP_W   = 2;
  localparam int POS_W  = 11;
  localparam int WORD_W = 32;
  localparam int ST_W   = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;        // capture request, decode, update count
    logic up_step;    // read one element of an upward move
    logic dn_step;    // read one element of a downward move
    logic fill_step;  // write one copy of the insert value
    logic fin;        // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic go_up;      // request is an insert that moves a tail
    logic go_fill;    // request is an insert that writes copies
    logic go_dn;      // request is an erase that moves a tail
    logic up_last;    // current upward read is the last one
    logic dn_last;    // current downward read is the last one
    logic fill_last;  // current fill write is the last one
    logic out_busy;   // result register cannot take a new result
  } sts_t;

endpackage

[design/pie_in_if.sv]
`timescale 1ns / 1ps
// Request channel interface: valid/ready handshake with the request fields.
// Depends on pie_pkg for field widths.
interface pie_in_if;
  import pie_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         position;
  logic [POS_W-1:0]         copies;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output op, output position, output copies,
                  output value, input ready);
  modport sink   (input valid, input op, input position, input copies,
                  input value, output ready);
endinterface

[design/pie_out_if.sv]
`timescale 1ns / 1ps
// Result channel interface: valid/ready handshake with the result fields.
// Depends on pie_pkg for field widths.
interface pie_out_if;
  import pie_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [POS_W-1:0]         count;
  logic [ST_W-1:0]          status;

  modport source (output valid, output read_value, output count, output status,
                  input ready);
  modport sink   (input valid, input read_value, input count, input status,
                   output ready);
endinterface

[design/pie_datapath.sv]
`timescale 1ns / 1ps
// Datapath: element memory, element count, move/fill counters, result register.
// Depends on pie_pkg; driven by pie_ctrl through cmd_t, reports through sts_t.
module pie_datapath #(
  parameter int CAPACITY = pie_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pie_pkg::cmd_t                    cmd,
  output pie_pkg::sts_t                    sts,
  input  logic [pie_pkg::OP_W-1:0]         in_op,
  input  logic [pie_pkg::POS_W-1:0]        in_position,
  input  logic [pie_pkg::POS_W-1:0]        in_copies,
  input  logic signed [pie_pkg::WORD_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [pie_pkg::WORD_W-1:0] out_read_value,
  output logic [pie_pkg::POS_W-1:0]        out_count,
  output logic [pie_pkg::ST_W-1:0]         out_status
);
  import pie_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Element storage and registered read port
  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rd_data_r;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  pos_r, copies_r, rem_r, idx_r, fill_r;
  logic [WORD_W-1:0] val_r;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic              rd_ok_r;
  logic              wr_pend_r;
  logic [AW-1:0]     wr_addr_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_value_r;
  logic [POS_W-1:0]  out_count_r;
  logic [ST_W-1:0]   out_status_r;

  logic [CW-1:0] pos_cw, cpy_cw, cnt_cw, sum_cw;
  logic          req_ok;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  // Request decode against the current count
  always_comb begin
    pos_cw  = CW'(in_position);
    cpy_cw  = CW'(in_copies);
    cnt_cw  = CW'(cnt_r);
    sum_cw  = cnt_cw + cpy_cw;
    req_ok  = 1'b0;
    st_nxt  = ST_OK;
    cnt_nxt = cnt_r;
    unique case (in_op)
      OP_READ: begin
        req_ok = (pos_cw < cnt_cw);
        st_nxt = req_ok ? ST_OK : ST_RANGE;
      end
      OP_INSERT: begin
        if (pos_cw > cnt_cw) begin
          st_nxt = ST_RANGE;
        end else if (sum_cw > CW'(CAPACITY)) begin
          st_nxt = ST_FULL;
        end else begin
          req_ok  = 1'b1;
          cnt_nxt = sum_cw[CNT_W-1:0];
        end
      end
      OP_ERASE: begin
        req_ok = (pos_cw < cnt_cw);
        st_nxt = req_ok ? ST_OK : ST_RANGE;
        if (req_ok) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        st_nxt = ST_RANGE;
      end
    endcase
  end

  assign sts.go_fill   = (in_op == OP_INSERT) && req_ok && (cpy_cw != '0);
  assign sts.go_up     = sts.go_fill && (pos_cw != cnt_cw);
  assign sts.go_dn     = (in_op == OP_ERASE) && req_ok && ((pos_cw + CW'(1)) != cnt_cw);
  assign sts.up_last   = (idx_r == pos_r);
  assign sts.dn_last   = (idx_r == cnt_r);
  assign sts.fill_last = (rem_r == CNT_W'(1));
  assign sts.out_busy  = out_valid_r && !out_ready;

  // Count, status and read-ok flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      st_r    <= ST_OK;
      rd_ok_r <= 1'b0;
    end else if (cmd.cap) begin
      cnt_r   <= cnt_nxt;
      st_r    <= st_nxt;
      rd_ok_r <= (in_op == OP_READ) && req_ok;
    end
  end

  // Request capture and move/fill counters
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      pos_r    <= pos_cw[CNT_W-1:0];
      copies_r <= cpy_cw[CNT_W-1:0];
      rem_r    <= cpy_cw[CNT_W-1:0];
      fill_r   <= pos_cw[CNT_W-1:0];
      val_r    <= in_value;
      idx_r    <= (in_op == OP_INSERT) ? (cnt_r - CNT_W'(1))
                                       : (pos_cw[CNT_W-1:0] + CNT_W'(1));
    end else begin
      if (cmd.up_step) begin
        idx_r <= idx_r - CNT_W'(1);
      end else if (cmd.dn_step) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.fill_step) begin
        fill_r <= fill_r + CNT_W'(1);
        rem_r  <= rem_r - CNT_W'(1);
      end
    end
  end

  // Pending move write, issued in the cycle after its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= cmd.up_step || cmd.dn_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.up_step) begin
      wr_addr_r <= AW'(idx_r + copies_r);
    end else if (cmd.dn_step) begin
      wr_addr_r <= AW'(idx_r - CNT_W'(1));
    end
  end

  // Memory ports: one read, one write per cycle
  assign rd_en   = (cmd.cap && (in_op == OP_READ) && req_ok) || cmd.up_step || cmd.dn_step;
  assign rd_addr = cmd.cap ? pos_cw[AW-1:0] : idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      mem[wr_addr_r] <= rd_data_r;
    end else if (cmd.fill_step) begin
      mem[fill_r[AW-1:0]] <= val_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_value_r  <= rd_ok_r ? rd_data_r : '0;
      out_count_r  <= cnt_cw[POS_W-1:0];
      out_status_r <= st_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_count      = out_count_r;
  assign out_status     = out_status_r;

endmodule

[design/pie_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences capture, tail moves, fill and result load.
// Depends on pie_pkg for cmd_t and sts_t.
module pie_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pie_pkg::sts_t sts,
  output pie_pkg::cmd_t cmd
);
  import pie_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UP     = 6'b000010,
    S_DN     = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_FILL   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   is_ins_r, is_ins_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    is_ins_nxt = is_ins_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          if (sts.go_up) begin
            state_nxt  = S_UP;
            is_ins_nxt = 1'b1;
          end else if (sts.go_fill) begin
            state_nxt = S_FILL;
          end else if (sts.go_dn) begin
            state_nxt  = S_DN;
            is_ins_nxt = 1'b0;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_UP: begin
        cmd.up_step = 1'b1;
        if (sts.up_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DN: begin
        cmd.dn_step = 1'b1;
        if (sts.dn_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last moved word is written this cycle
        state_nxt = is_ins_r ? S_FILL : S_RESULT;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      is_ins_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      is_ins_r <= is_ins_nxt;
    end
  end

endmodule

[design/positional_insert_erase_array.sv]
`timescale 1ns / 1ps
// Top level of the positional insert/erase array.
// Depends on pie_pkg, pie_in_if, pie_out_if, pie_ctrl and pie_datapath.
//
// Usage:
//   in_req carries one request per handshake (valid and ready high at a clock
//   edge): op, position, copies, value. out_rsp returns exactly one result per
//   request, in order: read_value, count, status.
//   Requests are handled one at a time; in_req.ready is high only while the
//   block is idle. Read, clear, any refused request and erase of the last
//   element go straight to the result. An erase first moves the T later
//   elements down, and an insert moves them up to make room and then writes
//   its C copies; words move through the element memory (one read and one
//   write port), one per cycle, and copies are written one per cycle. After
//   the result is loaded the block returns to idle and takes the next request.
//   The result sits in an output register; the block takes the next request
//   while it waits, and stalls only when a second result is ready before the
//   first is taken.
//   Reset (rst_n low, synchronous) empties the array and drops any pending
//   result. The memory is not cleared: words past the count are never read.
module positional_insert_erase_array #(
  parameter int CAPACITY = pie_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pie_in_if.sink    in_req,
  pie_out_if.source out_rsp
);
  import pie_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pie_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_req.op),
    .in_position    (in_req.position),
    .in_copies      (in_req.copies),
    .in_value       (in_req.value),
    .out_valid      (out_rsp.valid),
    .out_ready      (out_rsp.ready),
    .out_read_value (out_rsp.read_value),
    .out_count      (out_rsp.count),
    .out_status     (out_rsp.status)
  );

endmodule

[design/pie_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the positional insert/erase array, bound to the top.
// Depends on pie_pkg for widths and status codes.
module pie_checker #(
  parameter int CAPACITY = pie_pkg::CAPACITY_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [pie_pkg::WORD_W-1:0] out_read_value,
  input logic [pie_pkg::POS_W-1:0]         out_count,
  input logic [pie_pkg::ST_W-1:0]          out_status
);
  import pie_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_count) && $stable(out_status))
    else $error("result changed while stalled");

  // A result with error status returns zero data
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_read_value == '0))
    else $error("nonzero read_value with error status");

  // Count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_count) <= 32'(CAPACITY)))
    else $error("count above capacity");

  // One request at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

endmodule

bind positional_insert_erase_array pie_checker #(
  .CAPACITY (CAPACITY)
) u_pie_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_read_value (out_rsp.read_value),
  .out_count      (out_rsp.count),
  .out_status     (out_rsp.status)
);
